[design/sphp_pkg.sv]
package sphp_pkg;

	localparam int unsigned HdrLen = 6;
	localparam int unsigned QueueDepth = 4;
	localparam logic [2:0] ExpectedVersionReset = 3'd0;
	localparam logic [15:0] LengthLimitReset = 16'd1024;
	localparam logic [15:0] IndexMax = 16'hFFFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic REG_EXPECTED_VERSION = 1'b0;
	localparam logic REG_LENGTH_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_HDR_SHORT = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BUF_SHORT = 3'd3,
		ST_LEN_OVER = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] expected_version;
		logic [15:0] length_limit;
	} cfg_t;

	typedef struct packed {
		logic fwd;
		logic last;
		logic [7:0] data;
		status_t status;
		logic [47:0] hdr;
	} entry_t;

endpackage

[design/sphp_front.sv]
module sphp_front (
	input  logic clk,
	input  logic arst_n,
	input  sphp_pkg::cfg_t cfg,
	input  logic in_valid,
	input  logic [7:0] in_byte,
	input  logic in_last,
	input  logic q_ready,
	output logic in_ready,
	output logic push,
	output sphp_pkg::entry_t push_entry
);

	logic [15:0] byte_index_q;
	logic [47:0] hdr_q;
	logic [47:0] hdr_new;
	logic [15:0] count;
	logic [15:0] len;
	logic [16:0] fwd_end;
	logic [16:0] need_total;
	logic ok_hdr;
	logic ver_ok;
	logic fwd;
	logic have;
	logic accept;
	sphp_pkg::status_t st;

	assign in_ready = q_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		hdr_new = hdr_q;
		if (byte_index_q < 16'(sphp_pkg::HdrLen)) begin
			hdr_new = {hdr_q[39:0], in_byte};
		end
		len = hdr_new[15:0];
		ver_ok = hdr_new[47:45] == cfg.expected_version;
		ok_hdr = ver_ok && (len < cfg.length_limit);
		fwd_end = {1'b0, len} + 17'(sphp_pkg::HdrLen);
		need_total = {1'b0, len} + 17'(sphp_pkg::HdrLen + 1);
		fwd = (byte_index_q >= 16'(sphp_pkg::HdrLen)) && (byte_index_q != sphp_pkg::IndexMax)
			&& ok_hdr && ({1'b0, byte_index_q} <= fwd_end);
		count = (byte_index_q == sphp_pkg::IndexMax) ? sphp_pkg::IndexMax : byte_index_q + 16'd1;
		have = count >= 16'(sphp_pkg::HdrLen);
		if (!have) begin
			st = sphp_pkg::ST_HDR_SHORT;
		end else if (!ver_ok) begin
			st = sphp_pkg::ST_BAD_VERSION;
		end else if ({1'b0, count} < need_total) begin
			st = sphp_pkg::ST_BUF_SHORT;
		end else if (len >= cfg.length_limit) begin
			st = sphp_pkg::ST_LEN_OVER;
		end else begin
			st = sphp_pkg::ST_OK;
		end
		push_entry.fwd = fwd;
		push_entry.last = in_last;
		push_entry.data = in_byte;
		push_entry.status = st;
		push_entry.hdr = have ? hdr_new : 48'd0;
		push = accept && (fwd || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			hdr_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				byte_index_q <= '0;
				hdr_q <= '0;
			end else begin
				byte_index_q <= count;
				hdr_q <= hdr_new;
			end
		end
	end

endmodule

[design/sphp_queue.sv]
module sphp_queue #(
	parameter int unsigned Depth = sphp_pkg::QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sphp_pkg::entry_t push_entry,
	output logic ready,
	input  logic pop,
	output logic head_valid,
	output sphp_pkg::entry_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	sphp_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign ready = count_q != CntW'(Depth);
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(Depth))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count missed a push");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with misaligned pointers");

endmodule

[design/sphp_back.sv]
module sphp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  sphp_pkg::entry_t head,
	output logic pop,
	input  logic out_ready,
	output logic out_valid,
	output logic out_kind,
	output logic out_last,
	output logic [63:0] out_data
);

	logic valid_q;
	logic kind_q;
	logic last_q;
	logic [7:0] byte_q;
	sphp_pkg::status_t status_q;
	logic [47:0] hdr_q;
	logic phase_q;
	logic load;
	logic emit_payload;

	assign load = !valid_q || out_ready;
	assign emit_payload = head.fwd && !phase_q;
	assign pop = head_valid && load && !(emit_payload && head.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= emit_payload && head.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			hdr_q <= head.hdr;
			if (emit_payload) begin
				kind_q <= sphp_pkg::KIND_PAYLOAD;
				last_q <= !head.last;
				byte_q <= head.data;
				status_q <= sphp_pkg::ST_OK;
			end else begin
				kind_q <= sphp_pkg::KIND_STATUS;
				last_q <= 1'b1;
				byte_q <= 8'd0;
				status_q <= head.status;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_kind = kind_q;
	assign out_last = last_q;
	assign out_data = {5'd0, hdr_q[15:0], hdr_q[29:16], hdr_q[31:30], hdr_q[42:32],
		hdr_q[43], hdr_q[44], hdr_q[47:45], 3'(status_q), byte_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == sphp_pkg::KIND_STATUS) |-> last_q)
		else $error("status word without run end");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == sphp_pkg::KIND_PAYLOAD) |-> (status_q == sphp_pkg::ST_OK))
		else $error("payload word with nonzero status");
	assert property (@(posedge clk) disable iff (!arst_n) phase_q |-> head_valid)
		else $error("pending status lost its queue entry");

endmodule

[design/space_packet_header_parser.sv]
// A result word passes through the queue and then the output register before it is valid on the
// master side; the output register takes the queue head whenever it is empty or being read.
// Throughput: one byte per cycle; a final byte that also forwards payload yields two
// words, the payload word and then the status word; the queue absorbs it and the slave side stalls only when it fills.
// Reset: clears byte counter, header capture, queue and output valid; expected_version
// returns to 0 and length_limit to 1024.
module space_packet_header_parser #(
	parameter int unsigned QueueDepth = sphp_pkg::QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] payload_byte, [10:8] status, [13:11] version_field, [14] packet_type,
	// [15] sec_header_present, [26:16] apid, [28:27] seq_flags, [42:29] seq_count,
	// [58:43] data_length, [63:59] zero
	output logic [63:0] m_axis_tdata,
	output logic m_axis_tuser,         // [0] result_kind
	output logic m_axis_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	sphp_pkg::cfg_t cfg_q;
	sphp_pkg::entry_t push_entry;
	sphp_pkg::entry_t head;
	logic push;
	logic q_ready;
	logic head_valid;
	logic pop;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= sphp_pkg::ExpectedVersionReset;
			cfg_q.length_limit <= sphp_pkg::LengthLimitReset;
		end else if (wr_en) begin
			case (paddr[2])
				sphp_pkg::REG_EXPECTED_VERSION: cfg_q.expected_version <= pwdata[2:0];
				sphp_pkg::REG_LENGTH_LIMIT: cfg_q.length_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			sphp_pkg::REG_EXPECTED_VERSION: prdata = {29'd0, cfg_q.expected_version};
			sphp_pkg::REG_LENGTH_LIMIT: prdata = {16'd0, cfg_q.length_limit};
			default: prdata = 32'd0;
		endcase
	end

	sphp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_byte(s_axis_tdata),
		.in_last(s_axis_tlast),
		.q_ready(q_ready),
		.in_ready(s_axis_tready),
		.push(push),
		.push_entry(push_entry)
	);

	sphp_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.ready(q_ready),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	sphp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_kind(m_axis_tuser),
		.out_last(m_axis_tlast),
		.out_data(m_axis_tdata)
	);

endmodule

[sim/parse_checker.sv]
module parse_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
	input  logic s_axis_tlast,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] payload_byte, [10:8] status, [13:11] version_field, [14] packet_type,
	// [15] sec_header_present, [26:16] apid, [28:27] seq_flags, [42:29] seq_count,
	// [58:43] data_length
	input  logic [63:0] m_axis_tdata,
	input  logic m_axis_tuser,         // [0] result_kind
	input  logic m_axis_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sphp_pkg::*;

	typedef struct packed {
		logic kind;
		logic [7:0] payload;
		status_t status;
		logic [2:0] version;
		logic ptype;
		logic sec_hdr;
		logic [10:0] apid;
		logic [1:0] seq_flags;
		logic [13:0] seq_count;
		logic [15:0] dlen;
		logic run_end;
	} parsed_word_t;

	parsed_word_t words_due[$];
	logic [2:0] want_version = ExpectedVersionReset;
	logic [15:0] len_cap = LengthLimitReset;
	logic [15:0] byte_count = '0;
	logic [47:0] hdr_shift = '0;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic parsed_word_t header_view(logic [47:0] h);
		parsed_word_t w;
		w = '0;
		w.version = h[47:45];
		w.ptype = h[44];
		w.sec_hdr = h[43];
		w.apid = h[42:32];
		w.seq_flags = h[31:30];
		w.seq_count = h[29:16];
		w.dlen = h[15:0];
		return w;
	endfunction

	task automatic parse_byte(logic [7:0] b, logic last);
		logic [15:0] idx;
		logic [15:0] cnt;
		logic [2:0] ver;
		logic [15:0] len;
		logic ok;
		parsed_word_t w;
		idx = byte_count;
		if (idx < HdrLen) begin
			hdr_shift = {hdr_shift[39:0], b};
		end
		ver = hdr_shift[47:45];
		len = hdr_shift[15:0];
		ok = (ver == want_version) && (len < len_cap);
		if (idx >= HdrLen && idx != IndexMax && ok && 32'(idx) <= 32'(len) + HdrLen) begin
			w = header_view(hdr_shift);
			w.kind = KIND_PAYLOAD;
			w.payload = b;
			w.run_end = !last;
			words_due.push_back(w);
		end
		cnt = (idx != IndexMax) ? idx + 16'd1 : IndexMax;
		byte_count = cnt;
		if (last) begin
			w = (cnt >= HdrLen) ? header_view(hdr_shift) : '0;
			w.kind = KIND_STATUS;
			w.payload = '0;
			w.run_end = 1'b1;
			if (cnt < HdrLen) begin
				w.status = ST_HDR_SHORT;
			end else if (ver != want_version) begin
				w.status = ST_BAD_VERSION;
			end else if (32'(cnt) < 32'(len) + HdrLen + 1) begin
				w.status = ST_BUF_SHORT;
			end else if (len >= len_cap) begin
				w.status = ST_LEN_OVER;
			end else begin
				w.status = ST_OK;
			end
			words_due.push_back(w);
			byte_count = '0;
			hdr_shift = '0;
		end
	endtask

	task automatic report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	always @(posedge clk) begin
		parsed_word_t got;
		parsed_word_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LENGTH_LIMIT) begin
					len_cap = pwdata[15:0];
				end else begin
					want_version = pwdata[2:0];
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.payload = m_axis_tdata[7:0];
				got.status = status_t'(m_axis_tdata[10:8]);
				got.version = m_axis_tdata[13:11];
				got.ptype = m_axis_tdata[14];
				got.sec_hdr = m_axis_tdata[15];
				got.apid = m_axis_tdata[26:16];
				got.seq_flags = m_axis_tdata[28:27];
				got.seq_count = m_axis_tdata[42:29];
				got.dlen = m_axis_tdata[58:43];
				got.run_end = m_axis_tlast;
				if (words_due.size() == 0) begin
					report_mismatch("word with nothing expected");
				end else begin
					want = words_due.pop_front();
					check_field("result_kind", got.kind, want.kind);
					check_field("payload_byte", got.payload, want.payload);
					check_field("status", 16'(got.status), 16'(want.status));
					check_field("version_field", got.version, want.version);
					check_field("packet_type", got.ptype, want.ptype);
					check_field("sec_header_present", got.sec_hdr, want.sec_hdr);
					check_field("apid", got.apid, want.apid);
					check_field("seq_flags", got.seq_flags, want.seq_flags);
					check_field("seq_count", got.seq_count, want.seq_count);
					check_field("data_length", got.dlen, want.dlen);
					check_field("run_end", got.run_end, want.run_end);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata, s_axis_tlast);
			end
		end
		pending = words_due.size();
	end

endmodule

[sim/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sphp_pkg::*;

	localparam int StallMax = 13;
	localparam int StuckLimit = 1000;
	localparam int RandomBytes = 1350;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int errors;
	int pending;
	int sent = 0;
	int stuck_cycles = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	logic [2:0] cur_version = ExpectedVersionReset;
	logic [15:0] cur_limit = LengthLimitReset;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	space_packet_header_parser dut (.*);

	parse_checker chk (.*, .errors(errors), .pending(pending));

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				psel) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= StuckLimit) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		int n;
		n = 0;
		forever begin
			if (n % 24 == 0) begin
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			gap = rx_steady ? 0 : $urandom_range(0, StallMax);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			n++;
		end
	end

	task automatic put_byte(logic [7:0] b, logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, StallMax);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_buffer(logic [47:0] h, int total);
		for (int i = 0; i < total; i++) begin
			put_byte((i < HdrLen) ? h[47 - 8 * i -: 8] : 8'($urandom), i == total - 1);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [2:0] ver, logic [15:0] lim);
		drain();
		write_reg(REG_EXPECTED_VERSION, 16'(ver));
		write_reg(REG_LENGTH_LIMIT, lim);
		cur_version = ver;
		cur_limit = lim;
	endtask

	task automatic send_random_buffer();
		int pick;
		int total;
		logic [2:0] ver;
		logic [15:0] len;
		pick = $urandom_range(0, 99);
		ver = cur_version;
		len = 16'($urandom_range(0, 24));
		if (cur_limit != 0 && len >= cur_limit) begin
			len = 16'($urandom_range(0, cur_limit - 1));
		end
		total = HdrLen + len + 1;
		if (pick < 10) begin
			total = $urandom_range(HdrLen, HdrLen + len);
		end else if (pick < 18) begin
			total = $urandom_range(1, HdrLen - 1);
		end else if (pick < 28) begin
			total += $urandom_range(1, 4);
		end else if (pick < 36) begin
			ver = ver ^ 3'($urandom_range(1, 7));
		end else if (pick < 44 && cur_limit <= 40) begin
			len = cur_limit + 16'($urandom_range(0, 3));
			total = HdrLen + len + 1 + $urandom_range(0, 2);
		end else if (pick < 50) begin
			ver = 3'($urandom);
			len = 16'($urandom);
			total = $urandom_range(1, 14);
		end
		send_buffer({ver, 13'($urandom), 16'($urandom), len}, total);
	endtask

	task automatic set_random_config();
		logic [15:0] lim;
		case ($urandom_range(0, 5))
			0: lim = 16'd1;
			1: lim = 16'hFFFF;
			2: lim = LengthLimitReset;
			3: lim = 16'($urandom);
			default: lim = 16'($urandom_range(2, 40));
		endcase
		set_config(3'($urandom), lim);
	endtask

	initial begin
		int stop_at;
		int next_cfg;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_buffer(48'h0000_0000_0000, 7);
		send_buffer(48'hFFFF_FFFF_FFFF, 1);
		send_buffer(48'hE000_0000_0000, 6);
		send_buffer(48'h0000_0000_0002, 7);
		send_buffer({3'd0, 13'h1FFF, 16'hFFFF, 16'h0000}, 8);
		set_config(3'd7, 16'd1);
		send_buffer({3'd7, 29'h0, 16'd1}, 8);
		send_buffer({3'd7, 29'h1FFF_FFFF, 16'd0}, 8);
		set_config(3'd2, 16'd0);
		send_buffer({3'd2, 29'h0, 16'd0}, 7);

		stop_at = sent + RandomBytes;
		next_cfg = sent;
		while (sent < stop_at) begin
			if (sent >= next_cfg) begin
				set_random_config();
				next_cfg = sent + $urandom_range(80, 200);
			end
			tx_steady = ($urandom_range(0, 3) == 0);
			send_random_buffer();
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
